// ===== hw/rtl/sicbd_pkg.sv =====
package sicbd_pkg;

   localparam int unsigned MAX_BASE            = 16;
   localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;
   localparam int unsigned VALUE_W             = 32;
   localparam int unsigned CHAR_W              = 8;
   localparam int unsigned DIGIT_W             = 4;
   localparam int unsigned BASE_LEN_W          = 5;
   localparam int unsigned ALPHA_W             = 128;
   localparam int unsigned CSR_DATA_W          = 64;
   localparam int unsigned CSR_INDEX_W         = 2;
   localparam int unsigned MAX_DIGITS          = 32;
   localparam int unsigned DIG_IDX_W           = $clog2(MAX_DIGITS);

   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_BASE_LENGTH   = 2'd0,
      CSR_ALPHABET_LOW  = 2'd1,
      CSR_ALPHABET_HIGH = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_FIX,
      ST_SIGN,
      ST_EMIT
   } back_state_type;

   typedef struct packed {
      logic [BASE_LEN_W-1:0] base_length;
      logic [ALPHA_W-1:0]    alphabet;
   } sicbd_cfg_type;

   typedef struct packed {
      logic               neg;
      logic [VALUE_W-1:0] mag;
   } sicbd_job_type;

   function automatic logic [CHAR_W-1:0] alpha_char(input logic [ALPHA_W-1:0] alpha,
                                                    input logic [DIGIT_W-1:0] idx);
      alpha_char = alpha[{idx, 3'b000} +: CHAR_W];
   endfunction

   // floor(2^32 / radix); the quotient estimate it gives is at most one short.
   function automatic logic [VALUE_W-1:0] recip(input logic [BASE_LEN_W-1:0] radix);
      case (radix)
         5'd2:    recip = 32'h8000_0000;
         5'd3:    recip = 32'h5555_5555;
         5'd4:    recip = 32'h4000_0000;
         5'd5:    recip = 32'h3333_3333;
         5'd6:    recip = 32'h2AAA_AAAA;
         5'd7:    recip = 32'h2492_4924;
         5'd8:    recip = 32'h2000_0000;
         5'd9:    recip = 32'h1C71_C71C;
         5'd10:   recip = 32'h1999_9999;
         5'd11:   recip = 32'h1745_D174;
         5'd12:   recip = 32'h1555_5555;
         5'd13:   recip = 32'h13B1_3B13;
         5'd14:   recip = 32'h1249_2492;
         5'd15:   recip = 32'h1111_1111;
         5'd16:   recip = 32'h1000_0000;
         default: recip = '0;
      endcase
   endfunction

endpackage

// ===== hw/rtl/sicbd_front.sv =====
module sicbd_front import sicbd_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic signed [VALUE_W-1:0] req_value,
   input  logic                   queue_full,
   output logic                   push,
   output sicbd_job_type          job,
   output sicbd_cfg_type          cfg
);

   logic [BASE_LEN_W-1:0] base_length_ff;
   logic [CSR_DATA_W-1:0] alphabet_low_ff;
   logic [CSR_DATA_W-1:0] alphabet_high_ff;
   logic                  base_valid;

   function automatic logic base_ok(input sicbd_cfg_type c);
      logic              ok;
      logic [CHAR_W-1:0] ci;
      ok = (c.base_length >= BASE_LEN_W'(2)) && (c.base_length <= BASE_LEN_W'(MAX_BASE));
      for (int i = 0; i < MAX_BASE; i++) begin
         ci = alpha_char(c.alphabet, DIGIT_W'(i));
         if (BASE_LEN_W'(i) < c.base_length) begin
            if (ci == CHAR_PLUS || ci == CHAR_MINUS) begin
               ok = 1'b0;
            end
            for (int j = i + 1; j < MAX_BASE; j++) begin
               if (BASE_LEN_W'(j) < c.base_length &&
                   alpha_char(c.alphabet, DIGIT_W'(j)) == ci) begin
                  ok = 1'b0;
               end
            end
         end
      end
      base_ok = ok;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         base_length_ff   <= '0;
         alphabet_low_ff  <= '0;
         alphabet_high_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_BASE_LENGTH:   base_length_ff   <= csr_write_data[BASE_LEN_W-1:0];
            CSR_ALPHABET_LOW:  alphabet_low_ff  <= csr_write_data;
            CSR_ALPHABET_HIGH: alphabet_high_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign cfg.base_length = base_length_ff;
   assign cfg.alphabet    = {alphabet_high_ff, alphabet_low_ff};

   assign base_valid = base_ok(cfg);
   assign req_ready  = !queue_full;

   // Values arriving while the base is invalid are taken and dropped here.
   assign push    = req_valid && req_ready && base_valid;
   assign job.neg = req_value[VALUE_W-1];
   assign job.mag = req_value[VALUE_W-1] ? VALUE_W'(~req_value + 1'b1) : VALUE_W'(req_value);

endmodule

// ===== hw/rtl/sicbd_queue.sv =====
module sicbd_queue import sicbd_pkg::*; #(
   parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  sicbd_job_type push_data,
   output logic          full,
   input  logic          pop,
   output sicbd_job_type pop_data,
   output logic          not_empty
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   sicbd_job_type    entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hw/rtl/sicbd_back.sv =====
module sicbd_back import sicbd_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  sicbd_cfg_type      cfg,
   input  logic               job_valid,
   input  sicbd_job_type      job,
   output logic               job_pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [CHAR_W-1:0]  rsp_character,
   output logic               rsp_last
);

   back_state_type        state_ff, state_in;
   logic [VALUE_W-1:0]    mag_ff, mag_in;
   logic                  neg_ff, neg_in;
   logic [VALUE_W-1:0]    recip_ff, recip_in;
   logic [2*VALUE_W-1:0]  prod_ff, prod_in;
   logic [DIG_IDX_W-1:0]  dig_idx_ff, dig_idx_in;
   logic [DIGIT_W-1:0]    digits_ff [MAX_DIGITS];
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]     rsp_character_ff, rsp_character_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  slot_free;
   logic                  digit_we;
   logic [VALUE_W-1:0]    quot_est;
   logic [VALUE_W-1:0]    rem_est;
   logic                  need_fix;
   logic [5:0]            rem_fixed;
   logic [VALUE_W-1:0]    quot;
   logic [DIGIT_W-1:0]    digit;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign prod_in   = (2*VALUE_W)'(mag_ff) * (2*VALUE_W)'(recip_ff);

   // The estimate is the true quotient or one less, so the remainder is below
   // twice the radix and a single compare and subtract corrects it.
   assign quot_est  = prod_ff[2*VALUE_W-1:VALUE_W];
   assign rem_est   = mag_ff - VALUE_W'(quot_est * VALUE_W'(cfg.base_length));
   assign need_fix  = (rem_est[5:0] >= {1'b0, cfg.base_length});
   assign rem_fixed = rem_est[5:0] - {1'b0, cfg.base_length};
   assign quot      = need_fix ? quot_est + VALUE_W'(1) : quot_est;
   assign digit     = need_fix ? rem_fixed[DIGIT_W-1:0] : rem_est[DIGIT_W-1:0];

   always_comb begin
      state_in         = state_ff;
      mag_in           = mag_ff;
      neg_in           = neg_ff;
      recip_in         = recip_ff;
      dig_idx_in       = dig_idx_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_character_in = rsp_character_ff;
      rsp_last_in      = rsp_last_ff;
      job_pop          = 1'b0;
      digit_we         = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               job_pop    = 1'b1;
               mag_in     = job.mag;
               neg_in     = job.neg;
               recip_in   = recip(cfg.base_length);
               dig_idx_in = '0;
               state_in   = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_FIX;
         end
         ST_FIX: begin
            digit_we = 1'b1;
            mag_in   = quot;
            if (quot == '0 || dig_idx_ff == DIG_IDX_W'(MAX_DIGITS - 1)) begin
               state_in = neg_ff ? ST_SIGN : ST_EMIT;
            end else begin
               dig_idx_in = dig_idx_ff + DIG_IDX_W'(1);
               state_in   = ST_MUL;
            end
         end
         ST_SIGN: begin
            if (slot_free) begin
               rsp_valid_in     = 1'b1;
               rsp_character_in = CHAR_MINUS;
               rsp_last_in      = 1'b0;
               state_in         = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // Digits were stored least significant first, so they leave in reverse.
            if (slot_free) begin
               rsp_valid_in     = 1'b1;
               rsp_character_in = alpha_char(cfg.alphabet, digits_ff[dig_idx_ff]);
               rsp_last_in      = (dig_idx_ff == '0);
               if (dig_idx_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  dig_idx_in = dig_idx_ff - DIG_IDX_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff           <= mag_in;
      neg_ff           <= neg_in;
      recip_ff         <= recip_in;
      prod_ff          <= prod_in;
      dig_idx_ff       <= dig_idx_in;
      rsp_character_ff <= rsp_character_in;
      rsp_last_ff      <= rsp_last_in;
      if (digit_we) begin
         digits_ff[dig_idx_ff] <= digit;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_character_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

// ===== hw/rtl/signed_int_to_custom_base_digits_core.sv =====
// Converts a signed 32-bit value to text in a base set by a digit alphabet of up to
// sixteen characters, emitting one character per beat: a leading '-' for negatives,
// then digits from most significant down, with rsp_last on the final one. While the
// base is invalid (length below 2 or above 16, a repeated character, or a '+' or '-'
// in use), accepted values produce no beats. The front takes one value per cycle as
// long as the job queue has room; the back converts one value at a time, taking the
// job, then running a reciprocal multiply and its correction step for each digit,
// then emitting a '-' for a negative value and one character per beat while the
// result side is not stalled. Configuration takes effect on the next cycle.
module signed_int_to_custom_base_digits_core import sicbd_pkg::*; #(
   parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_write_data,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [VALUE_W-1:0] req_value,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [CHAR_W-1:0]         rsp_character,
   output logic                      rsp_last
);

   sicbd_cfg_type cfg;
   sicbd_job_type push_job;
   sicbd_job_type pop_job;
   logic          push;
   logic          pop;
   logic          queue_full;
   logic          queue_not_empty;

   sicbd_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_value        (req_value),
      .queue_full       (queue_full),
      .push             (push),
      .job              (push_job),
      .cfg              (cfg)
   );

   sicbd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_job),
      .full      (queue_full),
      .pop       (pop),
      .pop_data  (pop_job),
      .not_empty (queue_not_empty)
   );

   sicbd_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .job_valid     (queue_not_empty),
      .job           (pop_job),
      .job_pop       (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

endmodule

// ===== hw/rtl/sicbd_checker.sv =====
module sicbd_checker import sicbd_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [CHAR_W-1:0] rsp_character,
   input logic              rsp_last
);

   // A stalled result beat holds its character and flag.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_character) && $stable(rsp_last))
      else $error("result beat changed while stalled");

   // The sign is never the final character of a value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_character == CHAR_MINUS |-> !rsp_last)
      else $error("minus sign flagged as last");

   // A sign beat is followed by a digit, never by a second sign.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_character == CHAR_MINUS |=>
         !(rsp_valid && rsp_character == CHAR_MINUS))
      else $error("two sign characters in a row");

   // A valid base never holds '+', so it never reaches the output.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_character != CHAR_PLUS)
      else $error("plus character emitted");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid straight after reset");

endmodule

bind signed_int_to_custom_base_digits_core sicbd_checker u_sicbd_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_character (rsp_character),
   .rsp_last      (rsp_last)
);

// ===== sim/radix_text_checker.sv =====
`timescale 1ns / 1ps

module radix_text_checker import sicbd_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_write_data,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  logic signed [VALUE_W-1:0] req_value,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  logic [CHAR_W-1:0]         rsp_character,
   input  logic                      rsp_last,
   output int                        pending_count,
   output int                        mismatch_total
);

   typedef struct packed {
      logic [CHAR_W-1:0] glyph;
      logic              is_last;
   } text_beat_type;

   text_beat_type         expected_text[$];
   text_beat_type         head;
   logic [BASE_LEN_W-1:0] radix;
   logic [ALPHA_W-1:0]    glyphs;

   task automatic report_mismatch(input string what);
      mismatch_total++;
      $display("%0t ns: %s", $time, what);
   endtask

   function automatic logic [CHAR_W-1:0] glyph_at(input int idx);
      return glyphs[idx*CHAR_W +: CHAR_W];
   endfunction

   function automatic bit radix_usable();
      logic [CHAR_W-1:0] c;
      int                i;
      int                j;
      if (radix < 2 || radix > MAX_BASE) return 1'b0;
      for (i = 0; i < radix; i++) begin
         c = glyph_at(i);
         if (c == CHAR_PLUS || c == CHAR_MINUS) return 1'b0;
         for (j = i + 1; j < radix; j++)
            if (glyph_at(j) == c) return 1'b0;
      end
      return 1'b1;
   endfunction

   // Text of one value: the sign first, then the digits of the magnitude from the most
   // significant down. The most negative value keeps its full magnitude as unsigned.
   function automatic void render_value(input logic signed [VALUE_W-1:0] value);
      logic [VALUE_W-1:0] mag;
      logic [DIGIT_W-1:0] digit [MAX_DIGITS];
      int                 count;
      int                 k;
      if (!radix_usable()) return;
      mag = value;
      if (value[VALUE_W-1]) mag = ~mag + 1'b1;
      count = 0;
      do begin
         digit[count] = DIGIT_W'(mag % radix);
         mag          = mag / radix;
         count++;
      end while (mag != 0 && count < MAX_DIGITS);
      if (value[VALUE_W-1]) expected_text.push_back('{glyph: CHAR_MINUS, is_last: 1'b0});
      for (k = count - 1; k >= 0; k--)
         expected_text.push_back('{glyph: glyph_at(digit[k]), is_last: (k == 0)});
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         expected_text.delete();
         radix  = '0;
         glyphs = '0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_text.size() == 0) begin
               report_mismatch($sformatf("unexpected beat: character %02h, last %0b",
                                         rsp_character, rsp_last));
            end else begin
               head = expected_text.pop_front();
               if (rsp_character !== head.glyph)
                  report_mismatch($sformatf("character %02h, expected %02h",
                                            rsp_character, head.glyph));
               if (rsp_last !== head.is_last)
                  report_mismatch($sformatf("last %0b, expected %0b on character %02h",
                                            rsp_last, head.is_last, head.glyph));
            end
         end
         // A value is rendered with the base in force when its beat is taken.
         if (req_valid && req_ready) render_value(req_value);
         if (csr_write_enable) begin
            case (csr_index)
               CSR_BASE_LENGTH:   radix = csr_write_data[BASE_LEN_W-1:0];
               CSR_ALPHABET_LOW:  glyphs[CSR_DATA_W-1:0] = csr_write_data;
               CSR_ALPHABET_HIGH: glyphs[ALPHA_W-1:CSR_DATA_W] = csr_write_data;
               default: ;
            endcase
         end
      end
      pending_count <= expected_text.size();
   end

endmodule

// ===== sim/signed_int_to_custom_base_digits_core_test.sv =====
`timescale 1ns / 1ps

module signed_int_to_custom_base_digits_core_test import sicbd_pkg::*;;

   localparam int SETTLE_CYCLES = 400;
   localparam int RANDOM_VALUES = 470;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE     = 2'd3;
   localparam logic [VALUE_W-1:0]     MOST_NEGATIVE = 32'h8000_0000;
   localparam logic [VALUE_W-1:0]     MOST_POSITIVE = 32'h7FFF_FFFF;

   // Digits 0 to 9; the unused characters hold signs and repeats, which must not matter.
   localparam logic [ALPHA_W-1:0] DECIMAL = {64'h2B2D_3030_2B2D_3938, 64'h3736_3534_3332_3130};

   typedef enum int {
      FLAW_SHORT,
      FLAW_LONG,
      FLAW_REPEAT,
      FLAW_PLUS,
      FLAW_MINUS
   } base_flaw_type;

   logic                      clock            = 1'b0;
   logic                      reset            = 1'b1;
   logic                      csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0]    csr_index        = '0;
   logic [CSR_DATA_W-1:0]     csr_write_data   = '0;
   logic                      req_valid        = 1'b0;
   logic                      req_ready;
   logic signed [VALUE_W-1:0] req_value        = '0;
   logic                      rsp_valid;
   logic                      rsp_ready        = 1'b0;
   logic [CHAR_W-1:0]         rsp_character;
   logic                      rsp_last;

   int pending_count;
   int mismatch_total;
   int gap_pct   = 0;
   int stall_pct = 0;

   signed_int_to_custom_base_digits_core DUT (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_character    (rsp_character),
      .rsp_last         (rsp_last)
   );

   radix_text_checker text_check (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_character    (rsp_character),
      .rsp_last         (rsp_last),
      .pending_count    (pending_count),
      .mismatch_total   (mismatch_total)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   initial begin
      #20_000_000;
      $display("signed_int_to_custom_base_digits_core: mismatch");
      $finish;
   end

   // The count from the checker is registered, hence the edge before the first look.
   task automatic wait_drained(input bit settle);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      if (settle) repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic send_value(input logic [VALUE_W-1:0] value);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= value;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0]  data);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      @(posedge clock);
   endtask

   task automatic set_base(input int length, input logic [ALPHA_W-1:0] alphabet);
      logic [CSR_DATA_W-1:0] length_word;
      wait_drained(1'b1);
      // Bits above the length field are junk that the register must drop.
      length_word                 = {$urandom, $urandom};
      length_word[BASE_LEN_W-1:0] = length[BASE_LEN_W-1:0];
      write_csr(CSR_BASE_LENGTH, length_word);
      write_csr(CSR_ALPHABET_LOW, alphabet[CSR_DATA_W-1:0]);
      write_csr(CSR_ALPHABET_HIGH, alphabet[ALPHA_W-1:CSR_DATA_W]);
      write_csr(CSR_SPARE, {$urandom, $urandom});
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [ALPHA_W-1:0] random_alphabet(input int length);
      logic [ALPHA_W-1:0] alphabet;
      bit   [255:0]       taken;
      logic [CHAR_W-1:0]  c;
      int                 i;
      alphabet = {$urandom, $urandom, $urandom, $urandom};
      taken    = '0;
      for (i = 0; i < length; i++) begin
         do c = CHAR_W'($urandom_range(255));
         while (taken[c] || c == CHAR_PLUS || c == CHAR_MINUS);
         taken[c]                     = 1'b1;
         alphabet[i*CHAR_W +: CHAR_W] = c;
      end
      return alphabet;
   endfunction

   task automatic set_broken_base();
      base_flaw_type      flaw;
      logic [ALPHA_W-1:0] alphabet;
      int                 length;
      int                 i;
      int                 j;
      flaw     = base_flaw_type'($urandom_range(FLAW_MINUS));
      length   = $urandom_range(MAX_BASE, 2);
      alphabet = random_alphabet(length);
      i        = $urandom_range(length - 1);
      j        = (i + 1 + $urandom_range(length - 2)) % length;
      case (flaw)
         FLAW_SHORT:  length = $urandom_range(1);
         FLAW_LONG:   length = $urandom_range(31, MAX_BASE + 1);
         FLAW_REPEAT: alphabet[j*CHAR_W +: CHAR_W] = alphabet[i*CHAR_W +: CHAR_W];
         FLAW_PLUS:   alphabet[i*CHAR_W +: CHAR_W] = CHAR_PLUS;
         default:     alphabet[i*CHAR_W +: CHAR_W] = CHAR_MINUS;
      endcase
      set_base(length, alphabet);
   endtask

   function automatic logic [VALUE_W-1:0] pick_value();
      logic [VALUE_W-1:0] corners [5];
      logic [VALUE_W-1:0] value;
      corners = '{MOST_NEGATIVE, MOST_POSITIVE, 32'h0, 32'hFFFF_FFFF, 32'h8000_0001};
      case ($urandom_range(7))
         0: value = corners[$urandom_range(4)];
         1, 2: begin
            value = $urandom_range(999);
            if ($urandom_range(1)) value = -value;
         end
         default: value = $urandom;
      endcase
      return value;
   endfunction

   initial begin
      int n;
      int fed;
      int segment;
      int length;
      int count;
      int pause_at;
      fed     = 0;
      segment = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_base(10, DECIMAL);
      send_value(32'd0);
      send_value(32'd7);
      send_value(-32'sd1);
      send_value(MOST_POSITIVE);
      send_value(MOST_NEGATIVE);
      send_value(-32'sd905);

      set_base(2, {64'h0, 64'h2D2B_2D2B_2D2B_3130});
      send_value(MOST_NEGATIVE);
      send_value(MOST_POSITIVE);
      send_value(32'h5555_5555);

      // Full sixteen characters, a zero byte among them as digit zero.
      set_base(16, {64'hFEEF_DFBF_4020_10AA, 64'h0102_0408_7F80_FF00});
      send_value(-32'sd1);
      send_value(32'h89AB_CDEF);
      send_value(MOST_NEGATIVE);
      send_value(32'd0);

      // Bases that must give no text at all.
      set_base(1, DECIMAL);
      send_value(32'd5);
      set_base(0, DECIMAL);
      send_value(-32'sd5);
      set_base(17, DECIMAL);
      send_value(32'd12);
      set_base(31, DECIMAL);
      send_value(MOST_NEGATIVE);
      set_base(10, {64'h2B2D_3030_2B2D_3038, 64'h3736_3534_3332_3130});
      send_value(32'd99);
      set_base(10, {64'h2B2D_3030_2B2D_3938, 64'h3736_3534_2B32_3130});
      send_value(-32'sd42);
      set_base(10, {64'h2B2D_3030_2B2D_3938, 64'h3736_3534_3332_312D});
      send_value(32'd42);

      while (fed < RANDOM_VALUES) begin
         gap_pct   = (segment % 4 == 1) ? 46 : (segment % 4 == 3) ? 15 : 0;
         stall_pct = (segment % 4 == 2) ? 46 : (segment % 4 == 3) ? 15 : 0;
         if (segment % 6 == 5) begin
            set_broken_base();
            repeat (4) send_value(pick_value());
            fed += 4;
         end else begin
            length = (segment % 5 == 0) ? MAX_BASE :
                     (segment % 5 == 1) ? 2 : $urandom_range(MAX_BASE - 1, 3);
            set_base(length, random_alphabet(length));
            count    = $urandom_range(45, 25);
            if (count > RANDOM_VALUES - fed) count = RANDOM_VALUES - fed;
            pause_at = $urandom_range(count - 1);
            for (n = 0; n < count; n++) begin
               // Now and then hold off until every beat owed so far has come out.
               if (n == pause_at && segment % 3 == 0) wait_drained(1'b0);
               send_value(pick_value());
            end
            fed += count;
         end
         segment++;
      end

      wait_drained(1'b1);
      if (mismatch_total == 0) begin
         $display("signed_int_to_custom_base_digits_core: match");
      end else begin
         $display("signed_int_to_custom_base_digits_core: mismatch");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/sicbd_pkg.sv
hw/rtl/sicbd_front.sv
hw/rtl/sicbd_queue.sv
hw/rtl/sicbd_back.sv
hw/rtl/signed_int_to_custom_base_digits_core.sv
hw/rtl/sicbd_checker.sv
sim/radix_text_checker.sv
sim/signed_int_to_custom_base_digits_core_test.sv
